// File: design/llfg_pkg.sv
// ============================================================================
// llfg_pkg : shared types and constants of the LCG / lagged Fibonacci generator
// Register indexes, mode codes, sequencer states and the remainder unit's
// request and response records.
// ============================================================================
package llfg_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_MULT     = 3'd1;
    localparam logic [2:0] CFG_INCR     = 3'd2;
    localparam logic [2:0] CFG_LCG_MOD  = 3'd3;
    localparam logic [2:0] CFG_SEED     = 3'd4;
    localparam logic [2:0] CFG_FIB_MOD  = 3'd5;

    // mode codes; code 3 runs as plain LCG
    localparam logic [1:0] MODE_LCG     = 2'd0;
    localparam logic [1:0] MODE_MLCG    = 2'd1;
    localparam logic [1:0] MODE_LFG     = 2'd2;

    // remainder unit
    localparam int         MOD_CNT_W    = 7;
    localparam logic [MOD_CNT_W-1:0] LCG_BITS = 7'd63;
    localparam logic [MOD_CNT_W-1:0] FIB_BITS = 7'd32;

    typedef struct packed {
        logic                 start;
        logic [MOD_CNT_W-1:0] nbits;
    } t_mod_req;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_mod_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_LMOD,
        S_RD1,
        S_RD2,
        S_SUM,
        S_FMOD,
        S_DONE
    } t_state;

endpackage

// File: design/llfg_ram.sv
// ============================================================================
// llfg_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
module llfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/llfg_mod_unit.sv
// ============================================================================
// llfg_mod_unit : bit-serial remainder unit
// Restoring reduction, one dividend bit per cycle, MSB first. Done pulses
// the cycle after the last bit; the remainder holds until the next start.
// ============================================================================
module llfg_mod_unit
    import llfg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mod_req    i_req,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output t_mod_rsp    o_rsp
);

    logic [63:0]          r_div,  n_div;
    logic [31:0]          r_rem,  n_rem;
    logic [MOD_CNT_W-1:0] r_cnt,  n_cnt;
    logic                 r_done, n_done;
    logic [32:0]          trial;

    always_comb begin
        n_div  = r_div;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        trial  = {r_rem, r_div[63]};
        if (i_req.start) begin
            n_div = i_dividend;
            n_rem = '0;
            n_cnt = i_req.nbits;
        end else if (r_cnt != '0) begin
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = 32'(trial - {1'b0, i_divisor});
            end else begin
                n_rem = trial[31:0];
            end
            n_div  = {r_div[62:0], 1'b0};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == MOD_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// File: design/lcg_lagged_fibonacci_generator.sv
// ============================================================================
// lcg_lagged_fibonacci_generator : LCG / MLCG / additive lagged Fibonacci PRNG
// Each input beat requests one number; one result beat comes back per request.
// ============================================================================
// Each accepted beat yields exactly one result beat. In LCG mode the number is
// (a*x+c) mod m, in MLCG mode (a*x) mod m, both from the full 62-bit product.
// In lagged Fibonacci mode the first LONG_LAG numbers after a restart are LCG
// values that fill a ring; later ones are (ring[i-SHORT_LAG]+ring[i]) mod the
// Fibonacci modulus, written back over the oldest entry (modulus zero: no
// reduction). A seed not below the LCG modulus returns 0 with seed_bad set and
// advances nothing. Config writes land on the next clock and should only be
// made while the block is idle; a new seed takes effect on the next restart.
// Requests are served one at a time. An LCG/MLCG number goes through a
// multiply, an add, then a 63-bit serial reduction at one bit per cycle; a
// Fibonacci number takes two ring reads, then a 32-bit serial reduction,
// which a zero Fibonacci modulus skips. A bad seed goes straight to the
// result. The input is accepted only when the sequencer is idle; a finished
// result may still wait in the output register while the next request is
// taken.
// ============================================================================
module lcg_lagged_fibonacci_generator
    import llfg_pkg::*;
#(
    parameter int LONG_LAG  = 10,
    parameter int SHORT_LAG = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [30:0] o_random_value,
    output logic        o_seed_bad,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW      = $clog2(LONG_LAG);
    localparam int FW      = $clog2(LONG_LAG + 1);
    localparam int BACK    = SHORT_LAG % LONG_LAG;
    localparam int FWD     = LONG_LAG - BACK;
    localparam int LAST_I  = LONG_LAG - 1;
    localparam logic [AW:0]   LAG_L    = LONG_LAG[AW:0];
    localparam logic [AW:0]   LAG_FWD  = FWD[AW:0];
    localparam logic [AW-1:0] LAG_LAST = LAST_I[AW-1:0];
    localparam logic [FW-1:0] LAG_FULL = LONG_LAG[FW-1:0];

    // config
    logic [1:0]    r_mode, n_mode;
    logic [30:0]   r_mult, n_mult;
    logic [30:0]   r_incr, n_incr;
    logic [31:0]   r_lmod, n_lmod;
    logic [30:0]   r_seed, n_seed;
    logic [31:0]   r_fmod, n_fmod;

    // generator state
    t_state        r_state, n_state;
    logic [30:0]   r_lcg, n_lcg;
    logic [AW-1:0] r_ridx, n_ridx;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_inc_en, n_inc_en;
    logic          r_to_ring, n_to_ring;
    logic [61:0]   r_prod, n_prod;
    logic [30:0]   r_a, n_a;
    logic [30:0]   r_res_val, n_res_val;
    logic          r_res_bad, n_res_bad;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [30:0]   r_out_val, n_out_val;
    logic          r_out_bad, n_out_bad;

    // datapath glue
    t_mod_req      mod_req;
    t_mod_rsp      mod_rsp;
    logic [63:0]   mod_dividend;
    logic [31:0]   mod_divisor;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [30:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [30:0]   ram_rdata;

    logic [FW-1:0] fill_now;
    logic          seed_bad;
    logic [AW:0]   j_sum;
    logic [AW-1:0] ridx_back;
    logic [AW-1:0] ridx_adv;
    logic [62:0]   lcg_sum;
    logic [31:0]   fib_sum;

    // ring slot SHORT_LAG behind the oldest one, and the slot after the oldest
    always_comb begin
        j_sum     = {1'b0, r_ridx} + LAG_FWD;
        ridx_back = (j_sum >= LAG_L) ? AW'(j_sum - LAG_L) : j_sum[AW-1:0];
        ridx_adv  = (r_ridx == LAG_LAST) ? '0 : r_ridx + 1'b1;
    end

    assign seed_bad = ({1'b0, r_seed} >= r_lmod);
    assign fill_now = i_restart ? '0 : r_fill;
    assign lcg_sum  = {1'b0, r_prod} + (r_inc_en ? {32'b0, r_incr} : 63'b0);
    assign fib_sum  = {1'b0, r_a} + {1'b0, ram_rdata};

    always_comb begin
        n_mode      = r_mode;
        n_mult      = r_mult;
        n_incr      = r_incr;
        n_lmod      = r_lmod;
        n_seed      = r_seed;
        n_fmod      = r_fmod;
        n_state     = r_state;
        n_lcg       = r_lcg;
        n_ridx      = r_ridx;
        n_fill      = r_fill;
        n_inc_en    = r_inc_en;
        n_to_ring   = r_to_ring;
        n_prod      = r_prod;
        n_a         = r_a;
        n_res_val   = r_res_val;
        n_res_bad   = r_res_bad;
        n_out_valid = r_out_valid;
        n_out_val   = r_out_val;
        n_out_bad   = r_out_bad;

        mod_req.start = 1'b0;
        mod_req.nbits = LCG_BITS;
        mod_dividend  = {lcg_sum, 1'b0};
        mod_divisor   = r_lmod;
        ram_we        = 1'b0;
        ram_waddr     = r_ridx;
        ram_wdata     = mod_rsp.rem[30:0];
        ram_raddr     = r_ridx;

        // config writes
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:    n_mode = i_cfg_data[1:0];
                CFG_MULT:    n_mult = i_cfg_data[30:0];
                CFG_INCR:    n_incr = i_cfg_data[30:0];
                CFG_LCG_MOD: n_lmod = i_cfg_data;
                CFG_SEED:    n_seed = i_cfg_data[30:0];
                CFG_FIB_MOD: n_fmod = i_cfg_data;
                default:     ;
            endcase
        end

        // result beat taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_restart) begin
                        n_lcg  = r_seed;
                        n_ridx = '0;
                        n_fill = '0;
                    end
                    if (seed_bad) begin
                        n_res_val = '0;
                        n_res_bad = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        n_res_bad = 1'b0;
                        case (r_mode)
                            MODE_MLCG: begin
                                n_inc_en  = 1'b0;
                                n_to_ring = 1'b0;
                                n_state   = S_MUL;
                            end
                            MODE_LFG: begin
                                n_inc_en = 1'b1;
                                if (fill_now < LAG_FULL) begin
                                    n_to_ring = 1'b1;
                                    n_state   = S_MUL;
                                end else begin
                                    n_to_ring = 1'b0;
                                    n_state   = S_RD1;
                                end
                            end
                            default: begin
                                n_inc_en  = 1'b1;
                                n_to_ring = 1'b0;
                                n_state   = S_MUL;
                            end
                        endcase
                    end
                end
            end
            S_MUL: begin
                n_prod  = r_mult * r_lcg;
                n_state = S_ADD;
            end
            S_ADD: begin
                mod_req.start = 1'b1;
                mod_req.nbits = LCG_BITS;
                mod_dividend  = {lcg_sum, 1'b0};
                mod_divisor   = r_lmod;
                n_state       = S_LMOD;
            end
            S_LMOD: begin
                mod_divisor = r_lmod;
                if (mod_rsp.done) begin
                    n_lcg     = mod_rsp.rem[30:0];
                    n_res_val = mod_rsp.rem[30:0];
                    if (r_to_ring) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_fill[AW-1:0];
                        n_fill    = r_fill + 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_RD1: begin
                ram_raddr = r_ridx;
                n_state   = S_RD2;
            end
            S_RD2: begin
                ram_raddr = ridx_back;
                n_a       = ram_rdata;
                n_state   = S_SUM;
            end
            S_SUM: begin
                if (r_fmod == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ridx;
                    ram_wdata = fib_sum[30:0];
                    n_res_val = fib_sum[30:0];
                    n_ridx    = ridx_adv;
                    n_state   = S_DONE;
                end else begin
                    mod_req.start = 1'b1;
                    mod_req.nbits = FIB_BITS;
                    mod_dividend  = {fib_sum, 32'b0};
                    mod_divisor   = r_fmod;
                    n_state       = S_FMOD;
                end
            end
            S_FMOD: begin
                mod_divisor = r_fmod;
                if (mod_rsp.done) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ridx;
                    ram_wdata = mod_rsp.rem[30:0];
                    n_res_val = mod_rsp.rem[30:0];
                    n_ridx    = ridx_adv;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                // hand over once the output register is free or being drained
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_res_val;
                    n_out_bad   = r_res_bad;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LCG;
            r_mult      <= 31'd5;
            r_incr      <= 31'd3;
            r_lmod      <= 32'd16;
            r_seed      <= 31'd1;
            r_fmod      <= 32'd16;
            r_state     <= S_IDLE;
            r_lcg       <= 31'd1;
            r_ridx      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_mult      <= n_mult;
            r_incr      <= n_incr;
            r_lmod      <= n_lmod;
            r_seed      <= n_seed;
            r_fmod      <= n_fmod;
            r_state     <= n_state;
            r_lcg       <= n_lcg;
            r_ridx      <= n_ridx;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_inc_en  <= n_inc_en;
        r_to_ring <= n_to_ring;
        r_prod    <= n_prod;
        r_a       <= n_a;
        r_res_val <= n_res_val;
        r_res_bad <= n_res_bad;
        r_out_val <= n_out_val;
        r_out_bad <= n_out_bad;
    end

    llfg_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mod_req),
        .i_dividend (mod_dividend),
        .i_divisor  (mod_divisor),
        .o_rsp      (mod_rsp)
    );

    llfg_ram #(
        .WIDTH (31),
        .DEPTH (LONG_LAG)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_random_value = r_out_val;
    assign o_seed_bad     = r_out_bad;

endmodule
